// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the scoped symbol table.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int ENTRIES      = 64;
    localparam int MAX_LEVELS   = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SCOPE_W  = 4;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LVL_W  = $clog2(MAX_LEVELS);
    localparam int ENT_W  = KEY_BITS + PAYLOAD_BITS + LVL_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [REQ_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_ADD    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_UNDERFLOW = 3'd5
    } t_status;

    typedef struct packed {
        t_op                     op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_req;

endpackage

`default_nettype wire

// ===== hw/rtl/sst_front.sv =====
// ----------------------------------------------------------------------------
// sst_front
// Input stage: takes a request transfer, decodes it and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [sst_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [sst_pkg::KEY_BITS-1:0]     i_key,
    input  wire logic [sst_pkg::PAYLOAD_BITS-1:0] i_payload_in,
    output logic                                  o_push,
    output sst_pkg::t_req                         o_push_req,
    input  wire logic                             i_q_full
);
    import sst_pkg::*;

    logic r_valid;
    t_req r_req;
    logic w_accept;

    assign o_stall    = r_valid && i_q_full;
    assign w_accept   = i_valid && !o_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_push_req = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.op      <= t_op'(i_req_type);
            r_req.key     <= i_key;
            r_req.payload <= i_payload_in;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sst_queue.sv =====
// ----------------------------------------------------------------------------
// sst_queue
// Short request queue between the input stage and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sst_pkg::t_req      i_push_req,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_avail,
    output sst_pkg::t_req      o_head
);
    import sst_pkg::*;

    t_req              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_avail   = r_count != '0;
    assign o_head    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sst_back.sv =====
// ----------------------------------------------------------------------------
// sst_back
// Table engine: scans the entry memory one slot per cycle and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_avail,
    input  sst_pkg::t_req                          i_q_head,
    output logic                                   o_q_pop,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [sst_pkg::STATUS_W-1:0]           o_status,
    output logic [sst_pkg::PAYLOAD_BITS-1:0]       o_payload_out,
    output logic [sst_pkg::SCOPE_W-1:0]            o_scope_level
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                  r_state;
    t_req                    r_cur;
    logic [LVL_W-1:0]        r_level;
    logic [ENTRIES-1:0]      r_entry_vld;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_chk_vld;
    logic [IDX_W-1:0]        r_chk_idx;
    logic [ENT_W-1:0]        r_rdata;
    logic                    r_found;
    logic [PAYLOAD_BITS-1:0] r_found_pay;
    logic                    r_free_vld;
    logic [IDX_W-1:0]        r_free_idx;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    logic [LVL_W-1:0]        r_out_level;

    logic [ENT_W-1:0]        mem [ENTRIES];

    logic [KEY_BITS-1:0]     w_rd_key;
    logic [PAYLOAD_BITS-1:0] w_rd_pay;
    logic [LVL_W-1:0]        w_rd_lvl;
    logic                    w_chk_live;
    logic                    w_need_scan;
    logic                    w_addr_left;
    logic                    w_add_ok;
    t_status                 n_status;
    logic [PAYLOAD_BITS-1:0] n_pay;
    logic [LVL_W-1:0]        n_level;

    assign w_rd_key    = r_rdata[KEY_BITS-1:0];
    assign w_rd_pay    = r_rdata[KEY_BITS +: PAYLOAD_BITS];
    assign w_rd_lvl    = r_rdata[KEY_BITS + PAYLOAD_BITS +: LVL_W];
    assign w_chk_live  = r_chk_vld && r_entry_vld[r_chk_idx];
    assign w_addr_left = r_addr < CNT_W'(ENTRIES);
    assign w_need_scan = (i_q_head.op == OP_LOOKUP) || (i_q_head.op == OP_ADD)
                      || ((i_q_head.op == OP_POP) && (r_level != '0));
    assign w_add_ok    = (r_state == S_DONE) && (r_cur.op == OP_ADD)
                      && !r_found && r_free_vld;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_avail && !r_out_valid;

    always_comb begin
        n_status = ST_OK;
        n_pay    = '0;
        n_level  = r_level;
        case (r_cur.op)
            OP_PUSH: begin
                if (r_level == LVL_W'(MAX_LEVELS - 1)) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_level = r_level + 1'b1;
                end
            end
            OP_POP: begin
                if (r_level == '0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_level = r_level - 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (r_found) begin
                    n_pay = r_found_pay;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_ADD: begin
                if (r_found) begin
                    n_status = ST_DUPLICATE;
                end else if (!r_free_vld) begin
                    n_status = ST_FULL;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_entry_vld <= '0;
            r_addr      <= '0;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_free_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_addr     <= '0;
                        r_chk_vld  <= 1'b0;
                        r_found    <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_state    <= w_need_scan ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    r_chk_vld <= w_addr_left;
                    if (w_addr_left) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_chk_vld) begin
                        if (!r_entry_vld[r_chk_idx] && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                        end
                        if (w_chk_live && (w_rd_key == r_cur.key)) begin
                            r_found <= 1'b1;
                        end
                        if ((r_cur.op == OP_POP) && w_chk_live && (w_rd_lvl >= r_level)) begin
                            r_entry_vld[r_chk_idx] <= 1'b0;
                        end
                        if (r_chk_idx == IDX_W'(ENTRIES - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_level     <= n_level;
                    r_out_valid <= 1'b1;
                    if (w_add_ok) begin
                        r_entry_vld[r_free_idx] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_head;
        end
        if (r_state == S_SCAN) begin
            r_chk_idx <= r_addr[IDX_W-1:0];
            if (r_chk_vld && !r_entry_vld[r_chk_idx] && !r_free_vld) begin
                r_free_idx <= r_chk_idx;
            end
            if (w_chk_live && (w_rd_key == r_cur.key)) begin
                r_found_pay <= w_rd_pay;
            end
        end
        if (r_state == S_DONE) begin
            r_out_status <= n_status;
            r_out_pay    <= n_pay;
            r_out_level  <= n_level;
        end
    end

    // entry memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_add_ok) begin
            mem[r_free_idx] <= {r_level, r_cur.payload, r_cur.key};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_addr[IDX_W-1:0]];
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_payload_out = r_out_pay;
    assign o_scope_level = SCOPE_W'(r_out_level);

endmodule

`default_nettype wire

// ===== hw/rtl/scoped_symbol_table.sv =====
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Key/payload table with nested scopes: push, pop, lookup and add.
// ----------------------------------------------------------------------------
//  channel   handshake            fields
//  request   i_valid / o_stall    i_req_type, i_key, i_payload_in
//  result    o_valid / i_stall    o_status, o_payload_out, o_scope_level
//
//  push and underflowing pop go from the queue through the done state into the
//  result register; lookup, add and pop first scan every entry of the memory,
//  one read per cycle; the input register and queue precede the engine, which
//  takes the next request the cycle after its result transfer.
//  synchronous active-low reset empties the table and returns to the base scope.
//  a stalled result holds the engine; up to two requests plus the input register
//  still transfer in meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module scoped_symbol_table (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [sst_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [sst_pkg::KEY_BITS-1:0]     i_key,
    input  wire logic [sst_pkg::PAYLOAD_BITS-1:0] i_payload_in,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [sst_pkg::STATUS_W-1:0]          o_status,
    output logic [sst_pkg::PAYLOAD_BITS-1:0]      o_payload_out,
    output logic [sst_pkg::SCOPE_W-1:0]           o_scope_level
);
    import sst_pkg::*;

    logic w_push;
    t_req w_push_req;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_avail;
    t_req w_q_head;

    sst_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_payload_in (i_payload_in),
        .o_push       (w_push),
        .o_push_req   (w_push_req),
        .i_q_full     (w_q_full)
    );

    sst_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_req (w_push_req),
        .o_full     (w_q_full),
        .i_pop      (w_q_pop),
        .o_avail    (w_q_avail),
        .o_head     (w_q_head)
    );

    sst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_avail     (w_q_avail),
        .i_q_head      (w_q_head),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_payload_out (o_payload_out),
        .o_scope_level (o_scope_level)
    );

endmodule

`default_nettype wire
